// ----- rtl/hbb_pkg.sv -----
// ----------------------------------------------------------------------------
// hbb_pkg
// shared types, constants and codes of the homography bounding box block
// ----------------------------------------------------------------------------
`default_nettype none

package hbb_pkg;

   // fixed field widths
   localparam int PIXEL_W      = 12;
   localparam int FIELD_W      = 16;
   localparam int CSR_W        = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int COEF_COUNT   = 8;

   // fixed point layout
   localparam int FRAC_SHIFT    = 14;  // Q.16 numerator over Q.30 denominator
   localparam int DEN_ONE_SHIFT = 30;  // h33 = 1.0 in Q2.30

   // parameter defaults
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int OUT_BITS_DEFAULT   = 16;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      COEF_XX = 3'd0,
      COEF_XY = 3'd1,
      COEF_XT = 3'd2,
      COEF_YX = 3'd3,
      COEF_YY = 3'd4,
      COEF_YT = 3'd5,
      PERSP_X = 3'd6,
      PERSP_Y = 3'd7
   } hbb_coef_index_type;

   localparam logic signed [CSR_W-1:0] COEF_RESET [COEF_COUNT] = '{
      32'sd65536, 32'sd0, 32'sd0,
      32'sd0, 32'sd65536, 32'sd0,
      32'sd0, 32'sd0
   };

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC_COL,
      ST_MAC_ROW,
      ST_PREP,
      ST_LOAD,
      ST_DIVIDE,
      ST_ROUND,
      ST_UPDATE
   } hbb_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic mac_col;
      logic mac_row;
      logic prep;
      logic div_load;
      logic div_step;
      logic round;
      logic update;
   } hbb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic den_nonpos;
   } hbb_status_type;

endpackage

`default_nettype wire

// ----- rtl/hbb_divider.sv -----
// ----------------------------------------------------------------------------
// hbb_divider
// restoring divider, one quotient bit per step, with round-half-even flag
// ----------------------------------------------------------------------------
`default_nettype none

module hbb_divider
   import hbb_pkg::*;
#(
   parameter int MAG_W    = CSR_W + COORD_BITS_DEFAULT + 1,
   parameter int OUT_BITS = OUT_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                load,
   input  wire logic                step,
   input  wire logic [MAG_W-1:0]    num,
   input  wire logic [MAG_W-1:0]    den,
   output logic      [OUT_BITS:0]   quo,
   output logic                     ovf,
   output logic                     round_up
);

   localparam int REM_W = MAG_W + OUT_BITS + 2;

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  dsh_ff, dsh_in;
   logic [MAG_W-1:0]  den_ff, den_in;
   logic [OUT_BITS:0] quo_ff, quo_in;
   logic              ovf_ff, ovf_in;

   logic [REM_W-1:0]  rem_load;
   logic [REM_W-1:0]  den_wide;
   logic [REM_W-1:0]  rem_diff;
   logic              fits;
   logic [MAG_W:0]    twice_rem;

   assign rem_load = REM_W'({num, {FRAC_SHIFT{1'b0}}});
   assign den_wide = REM_W'(den);
   assign rem_diff = rem_ff - dsh_ff;
   assign fits     = rem_ff >= dsh_ff;

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      if (load) begin
         rem_in = rem_load;
         dsh_in = den_wide << OUT_BITS;
         den_in = den;
         quo_in = '0;
         // quotient would not fit in the bits produced
         ovf_in = rem_load >= (den_wide << (OUT_BITS + 1));
      end else if (step) begin
         if (fits) begin
            rem_in = rem_diff;
         end
         quo_in = {quo_ff[OUT_BITS-1:0], fits};
         dsh_in = dsh_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   // remainder is below the divisor once all steps are done
   assign twice_rem = {rem_ff[MAG_W-1:0], 1'b0};
   assign round_up  = (twice_rem > {1'b0, den_ff}) ||
                      ((twice_rem == {1'b0, den_ff}) && quo_ff[0]);
   assign quo       = quo_ff;
   assign ovf       = ovf_ff;

endmodule

`default_nettype wire

// ----- rtl/hbb_datapath.sv -----
// ----------------------------------------------------------------------------
// hbb_datapath
// coefficient registers, projective sums, dividers, rounding and box
// ----------------------------------------------------------------------------
`default_nettype none

module hbb_datapath
   import hbb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int OUT_BITS   = OUT_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hbb_cmd_type                cmd,
   output hbb_status_type                  status,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [CSR_W-1:0]           csr_wdata,
   input  wire logic [PIXEL_W-1:0]         req_pixel_col,
   input  wire logic [PIXEL_W-1:0]         req_pixel_row,
   input  wire logic                       req_frame_start,
   input  wire logic                       req_frame_end,
   output logic signed [FIELD_W-1:0]       rsp_mapped_col,
   output logic signed [FIELD_W-1:0]       rsp_mapped_row,
   output logic                            rsp_saturated,
   output logic signed [FIELD_W-1:0]       rsp_box_min_col,
   output logic signed [FIELD_W-1:0]       rsp_box_max_col,
   output logic signed [FIELD_W-1:0]       rsp_box_min_row,
   output logic signed [FIELD_W-1:0]       rsp_box_max_row,
   output logic                            rsp_box_final
);

   localparam int PROD_W    = CSR_W + COORD_BITS + 1;
   localparam int NUM_W     = PROD_W + 1;
   localparam int MAG_W     = PROD_W;
   localparam int PIX_EXT_W = (COORD_BITS > PIXEL_W) ? COORD_BITS : PIXEL_W;
   localparam int EXT_W     = (OUT_BITS > FIELD_W) ? OUT_BITS : FIELD_W;

   localparam logic signed [NUM_W-1:0] DEN_ONE   = NUM_W'(64'd1 << DEN_ONE_SHIFT);
   localparam logic [OUT_BITS+1:0]     LIM       = {3'b001, {(OUT_BITS-1){1'b0}}};
   localparam logic [OUT_BITS+1:0]     LIM_M1    = {3'b000, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0]     MAX_POS   = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0]     MIN_NEG   = {1'b1, {(OUT_BITS-1){1'b0}}};

   // rounded quotient to signed value, msb is the clip flag
   function automatic logic [OUT_BITS:0] round_clip(
      input logic [OUT_BITS:0] quo,
      input logic              up,
      input logic              ovf,
      input logic              neg
   );
      logic [OUT_BITS+1:0] qr;
      logic [OUT_BITS+1:0] negq;
      logic [OUT_BITS-1:0] val;
      logic                clip;
      qr   = {1'b0, quo} + {{(OUT_BITS+1){1'b0}}, up};
      negq = ~qr + {{(OUT_BITS+1){1'b0}}, 1'b1};
      if (neg) begin
         clip = ovf || (qr > LIM);
         val  = clip ? MIN_NEG : negq[OUT_BITS-1:0];
      end else begin
         clip = ovf || (qr > LIM_M1);
         val  = clip ? MAX_POS : qr[OUT_BITS-1:0];
      end
      return {clip, val};
   endfunction

   // low field bits of the zero-extended value
   function automatic logic [FIELD_W-1:0] to_field(input logic [OUT_BITS-1:0] v);
      logic [EXT_W-1:0] w;
      w = EXT_W'(v);
      return w[FIELD_W-1:0];
   endfunction

   // coefficient registers
   logic signed [CSR_W-1:0] coef_ff [COEF_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_COUNT; i++) begin
            coef_ff[i] <= COEF_RESET[i];
         end
      end else if (csr_write_en) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // captured transaction
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic                  start_ff, final_ff;
   logic [PIX_EXT_W-1:0]  col_wide, row_wide;

   assign col_wide = PIX_EXT_W'(req_pixel_col);
   assign row_wide = PIX_EXT_W'(req_pixel_row);
   assign col_in   = col_wide[COORD_BITS-1:0];
   assign row_in   = row_wide[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         start_ff <= req_frame_start;
         final_ff <= req_frame_end;
      end
   end

   // three multiply-accumulates, column term first then row term
   logic signed [COORD_BITS:0] coord_s;
   logic signed [CSR_W-1:0]    mc_x, mc_y, mc_d;
   logic signed [PROD_W-1:0]   prod_x, prod_y, prod_d;
   logic signed [NUM_W-1:0]    acc_x_ff, acc_x_in;
   logic signed [NUM_W-1:0]    acc_y_ff, acc_y_in;
   logic signed [NUM_W-1:0]    acc_d_ff, acc_d_in;

   assign coord_s = $signed({1'b0, cmd.mac_row ? row_ff : col_ff});
   assign mc_x    = cmd.mac_row ? coef_ff[COEF_XY] : coef_ff[COEF_XX];
   assign mc_y    = cmd.mac_row ? coef_ff[COEF_YY] : coef_ff[COEF_YX];
   assign mc_d    = cmd.mac_row ? coef_ff[PERSP_Y] : coef_ff[PERSP_X];
   assign prod_x  = mc_x * coord_s;
   assign prod_y  = mc_y * coord_s;
   assign prod_d  = mc_d * coord_s;

   always_comb begin
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      acc_d_in = acc_d_ff;
      if (cmd.mac_col) begin
         acc_x_in = NUM_W'(prod_x) + NUM_W'(coef_ff[COEF_XT]);
         acc_y_in = NUM_W'(prod_y) + NUM_W'(coef_ff[COEF_YT]);
         acc_d_in = NUM_W'(prod_d) + DEN_ONE;
      end else if (cmd.mac_row) begin
         acc_x_in = NUM_W'(prod_x) + acc_x_ff;
         acc_y_in = NUM_W'(prod_y) + acc_y_ff;
         acc_d_in = NUM_W'(prod_d) + acc_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
      acc_d_ff <= acc_d_in;
   end

   // magnitudes and signs for the dividers
   logic signed [NUM_W-1:0] abs_x, abs_y;
   logic [MAG_W-1:0]        mag_x_ff, mag_y_ff, mag_d_ff;
   logic                    neg_x_ff, neg_y_ff, den_nonpos_ff;

   assign abs_x = acc_x_ff[NUM_W-1] ? -acc_x_ff : acc_x_ff;
   assign abs_y = acc_y_ff[NUM_W-1] ? -acc_y_ff : acc_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         mag_x_ff      <= abs_x[MAG_W-1:0];
         mag_y_ff      <= abs_y[MAG_W-1:0];
         mag_d_ff      <= acc_d_ff[MAG_W-1:0];
         neg_x_ff      <= acc_x_ff[NUM_W-1];
         neg_y_ff      <= acc_y_ff[NUM_W-1];
         den_nonpos_ff <= acc_d_ff[NUM_W-1] || (acc_d_ff == '0);
      end
   end

   assign status.den_nonpos = den_nonpos_ff;

   logic [OUT_BITS:0] quo_x, quo_y;
   logic              ovf_x, ovf_y, up_x, up_y;

   hbb_divider #(
      .MAG_W    (MAG_W),
      .OUT_BITS (OUT_BITS)
   ) u_div_x (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .num      (mag_x_ff),
      .den      (mag_d_ff),
      .quo      (quo_x),
      .ovf      (ovf_x),
      .round_up (up_x)
   );

   hbb_divider #(
      .MAG_W    (MAG_W),
      .OUT_BITS (OUT_BITS)
   ) u_div_y (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .num      (mag_y_ff),
      .den      (mag_d_ff),
      .quo      (quo_y),
      .ovf      (ovf_y),
      .round_up (up_y)
   );

   // rounding and clipping
   logic [OUT_BITS:0]           rc_x, rc_y;
   logic signed [OUT_BITS-1:0]  mx_ff, mx_in, my_ff, my_in;
   logic                        sat_ff, sat_in;

   assign rc_x = round_clip(quo_x, up_x, ovf_x, neg_x_ff);
   assign rc_y = round_clip(quo_y, up_y, ovf_y, neg_y_ff);

   always_comb begin
      if (den_nonpos_ff) begin
         mx_in  = neg_x_ff ? MIN_NEG : MAX_POS;
         my_in  = neg_y_ff ? MIN_NEG : MAX_POS;
         sat_in = 1'b1;
      end else begin
         mx_in  = rc_x[OUT_BITS-1:0];
         my_in  = rc_y[OUT_BITS-1:0];
         sat_in = rc_x[OUT_BITS] || rc_y[OUT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.round) begin
         mx_ff  <= mx_in;
         my_ff  <= my_in;
         sat_ff <= sat_in;
      end
   end

   // bounding box
   logic signed [OUT_BITS-1:0] min_col_ff, min_col_in, max_col_ff, max_col_in;
   logic signed [OUT_BITS-1:0] min_row_ff, min_row_in, max_row_ff, max_row_in;

   always_comb begin
      if (start_ff) begin
         min_col_in = mx_ff;
         max_col_in = mx_ff;
         min_row_in = my_ff;
         max_row_in = my_ff;
      end else begin
         min_col_in = (mx_ff < min_col_ff) ? mx_ff : min_col_ff;
         max_col_in = (mx_ff > max_col_ff) ? mx_ff : max_col_ff;
         min_row_in = (my_ff < min_row_ff) ? my_ff : min_row_ff;
         max_row_in = (my_ff > max_row_ff) ? my_ff : max_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_col_ff <= '0;
         max_col_ff <= '0;
         min_row_ff <= '0;
         max_row_ff <= '0;
      end else if (cmd.update) begin
         min_col_ff <= min_col_in;
         max_col_ff <= max_col_in;
         min_row_ff <= min_row_in;
         max_row_ff <= max_row_in;
      end
   end

   // response register; apart from reset, the box registers change only with it
   logic [FIELD_W-1:0] out_col_ff, out_row_ff;
   logic               out_sat_ff, out_final_ff;

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         out_col_ff   <= to_field(mx_ff);
         out_row_ff   <= to_field(my_ff);
         out_sat_ff   <= sat_ff;
         out_final_ff <= final_ff;
      end
   end

   assign rsp_mapped_col  = $signed(out_col_ff);
   assign rsp_mapped_row  = $signed(out_row_ff);
   assign rsp_saturated   = out_sat_ff;
   assign rsp_box_min_col = $signed(to_field(min_col_ff));
   assign rsp_box_max_col = $signed(to_field(max_col_ff));
   assign rsp_box_min_row = $signed(to_field(min_row_ff));
   assign rsp_box_max_row = $signed(to_field(max_row_ff));
   assign rsp_box_final   = out_final_ff;

endmodule

`default_nettype wire

// ----- rtl/hbb_ctrl.sv -----
// ----------------------------------------------------------------------------
// hbb_ctrl
// sequencer for one transaction: sums, division steps, rounding, response
// ----------------------------------------------------------------------------
`default_nettype none

module hbb_ctrl
   import hbb_pkg::*;
#(
   parameter int OUT_BITS = OUT_BITS_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output hbb_cmd_type         cmd,
   input  wire hbb_status_type status
);

   localparam int STEP_W = $clog2(OUT_BITS + 1);

   hbb_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_MAC_COL;
            end
         end
         ST_MAC_COL: begin
            cmd.mac_col = 1'b1;
            state_in    = ST_MAC_ROW;
         end
         ST_MAC_ROW: begin
            cmd.mac_row = 1'b1;
            state_in    = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            // nothing to divide when the denominator is not positive
            state_in     = status.den_nonpos ? ST_ROUND : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(OUT_BITS)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/homography_bounding_box.sv -----
// ----------------------------------------------------------------------------
// homography_bounding_box
// projective mapping of a pixel scan with a running bounding box
// ----------------------------------------------------------------------------
// Each request transaction carries one source pixel; it is mapped through the
// 3x3 projective matrix held in the csr registers (h33 fixed at 1.0), rounded
// half to even, saturated to OUT_BITS signed and folded into the bounding box,
// and one response transaction returns the point, the saturation flag and the
// box after the update. A transaction runs through the column and row sums,
// magnitude prep, divider load, the steps of the restoring dividers (one
// quotient bit per cycle), rounding and the response update, skipping the
// division steps when the denominator is not positive. The next request is
// accepted in the cycle after the result is handed to the response register,
// so a response that waits on rsp_ready does not hold up the following point
// until that one is done as well. Csr writes are meant for idle periods only;
// values are signed Q16.16 for the affine terms and Q2.30 for the perspective
// terms. Mapped and box fields carry the low 16 bits of the OUT_BITS result.
// ----------------------------------------------------------------------------
`default_nettype none

module homography_bounding_box
   import hbb_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int OUT_BITS   = OUT_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // csr write port
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]       csr_wdata,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [PIXEL_W-1:0]     req_pixel_col,
   input  wire logic [PIXEL_W-1:0]     req_pixel_row,
   input  wire logic                   req_frame_start,
   input  wire logic                   req_frame_end,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [FIELD_W-1:0]   rsp_mapped_col,
   output logic signed [FIELD_W-1:0]   rsp_mapped_row,
   output logic                        rsp_saturated,
   output logic signed [FIELD_W-1:0]   rsp_box_min_col,
   output logic signed [FIELD_W-1:0]   rsp_box_max_col,
   output logic signed [FIELD_W-1:0]   rsp_box_min_row,
   output logic signed [FIELD_W-1:0]   rsp_box_max_row,
   output logic                        rsp_box_final
);

   // command and status between sequencer and datapath
   hbb_cmd_type    cmd;
   hbb_status_type status;

   // sequencer: accept, sums, divide steps, round, hand off response
   hbb_ctrl #(
      .OUT_BITS (OUT_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: csr registers, multiply-accumulate, dividers, box
   hbb_datapath #(
      .COORD_BITS (COORD_BITS),
      .OUT_BITS   (OUT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_row   (req_pixel_row),
      .req_frame_start (req_frame_start),
      .req_frame_end   (req_frame_end),
      .rsp_mapped_col  (rsp_mapped_col),
      .rsp_mapped_row  (rsp_mapped_row),
      .rsp_saturated   (rsp_saturated),
      .rsp_box_min_col (rsp_box_min_col),
      .rsp_box_max_col (rsp_box_max_col),
      .rsp_box_min_row (rsp_box_min_row),
      .rsp_box_max_row (rsp_box_max_row),
      .rsp_box_final   (rsp_box_final)
   );

endmodule

`default_nettype wire
